/* rtl/core/ppsu_pkg.sv */
// shared types and constants of the particle pool spawn and update block
// no dependencies; every other file in rtl/core but ppsu_ram imports this package

package ppsu_pkg;

	localparam int POOL_SIZE = 512;
	localparam int ADDR_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int CFG_W     = 10;
	localparam int SLOT_W    = 9;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 10'd512;

	localparam logic [16:0]       LIFE_FULL     = 17'd65536;
	localparam logic [16:0]       ALPHA_FULL    = 17'd65536;
	localparam logic [7:0]        SHADE_BASE    = 8'd50;
	localparam logic signed [7:0] OFFSET_CENTRE = 8'sd50;
	localparam logic [15:0]       HALF_Q16      = 16'd32768;

	// reciprocals rounded up; exact over the operand ranges they see
	localparam logic [15:0] RECIP_5     = 16'd52429;
	localparam logic [13:0] ROUND_5     = 14'd2;
	localparam int          RECIP_5_SH  = 18;
	localparam logic [23:0] RECIP_10    = 24'd13421773;
	localparam logic [23:0] ROUND_10    = 24'd5;
	localparam int          RECIP_10_SH = 27;

	typedef enum logic [1:0] {
		ACT_SPAWN = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [15:0]        dt;
		logic signed [23:0] spawn_x;
		logic signed [23:0] spawn_y;
		logic signed [23:0] source_vel_x;
		logic signed [23:0] source_vel_y;
		logic [6:0]         offset_pick;
		logic [6:0]         shade_pick;
		logic [8:0]         read_slot;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [16:0]        alpha;
		logic [7:0]         shade;
		logic               alive;
	} result_t;

	typedef struct packed {
		logic [16:0]        life;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [16:0]        alpha;
		logic [7:0]         shade;
	} slot_rec_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic walk;
		logic spawn_commit;
		logic read_commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hit;
		logic walk_done;
		logic out_free;
	} stat_t;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607) begin
			return 24'sd8388607;
		end else if (v < -26'sd8388608) begin
			return -24'sd8388608;
		end
		return 24'(v);
	endfunction

endpackage

/* rtl/core/ppsu_ifs.sv */
// valid/ready channel interfaces: input item, result and configuration write
// depends on ppsu_pkg

interface ppsu_item_if;
	import ppsu_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [15:0]        dt;
	logic signed [23:0] spawn_x;
	logic signed [23:0] spawn_y;
	logic signed [23:0] source_vel_x;
	logic signed [23:0] source_vel_y;
	logic [6:0]         offset_pick;
	logic [6:0]         shade_pick;
	logic [8:0]         read_slot;

	modport source (
		output valid, action, dt, spawn_x, spawn_y, source_vel_x, source_vel_y,
		output offset_pick, shade_pick, read_slot,
		input  ready
	);
	modport sink (
		input  valid, action, dt, spawn_x, spawn_y, source_vel_x, source_vel_y,
		input  offset_pick, shade_pick, read_slot,
		output ready
	);
endinterface

interface ppsu_result_if;
	import ppsu_pkg::*;
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  slot;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic [16:0]        alpha;
	logic [7:0]         shade;
	logic               alive;

	modport source (output valid, slot, pos_x, pos_y, alpha, shade, alive, input ready);
	modport sink (input valid, slot, pos_x, pos_y, alpha, shade, alive, output ready);
endinterface

interface ppsu_cfg_if;
	import ppsu_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] active_slots;

	modport source (output valid, active_slots, input ready);
	modport sink (input valid, active_slots, output ready);
endinterface

/* rtl/core/particle_pool_spawn_update.sv */
// top level of the particle pool spawn and update block
// depends on ppsu_pkg, ppsu_ifs, ppsu_ctrl, ppsu_dpath (and ppsu_ram below it)

// Pool of 512 particles held in one single-port-read slot ram. After reset
// a clearing pass writes every slot to zero, during which no request is
// taken (configuration writes are). All work walks the ram read port one
// slot per cycle: a tick walks all active slots, a spawn walks from the
// last spawned slot to the first free slot (the whole active pool when
// the pool is full), and a read fetches its one slot. One request is in
// flight at a time; results sit in an output register, so the next
// request is taken while a result waits. active_slots should be written
// only while the block is idle.

module particle_pool_spawn_update (
	input  logic    clk,
	input  logic    arst_n,
	ppsu_item_if.sink     item,
	ppsu_cfg_if.sink      cfg,
	ppsu_result_if.source result
);
	import ppsu_pkg::*;

	item_t   item_data;
	result_t res_data;
	logic    res_valid;
	cmd_t    cmd;
	stat_t   stat;

	always_comb begin
		item_data.action       = action_t'(item.action);
		item_data.dt           = item.dt;
		item_data.spawn_x      = item.spawn_x;
		item_data.spawn_y      = item.spawn_y;
		item_data.source_vel_x = item.source_vel_x;
		item_data.source_vel_y = item.source_vel_y;
		item_data.offset_pick  = item.offset_pick;
		item_data.shade_pick   = item.shade_pick;
		item_data.read_slot    = item.read_slot;
	end

	assign cfg.ready = 1'b1;

	ppsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item_data.action),
		.in_ready  (item.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ppsu_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item_data (item_data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.active_slots),
		.res_data  (res_data),
		.res_valid (res_valid),
		.res_ready (result.ready)
	);

	assign result.valid = res_valid;
	assign result.slot  = res_data.slot;
	assign result.pos_x = res_data.pos_x;
	assign result.pos_y = res_data.pos_y;
	assign result.alpha = res_data.alpha;
	assign result.shade = res_data.shade;
	assign result.alive = res_data.alive;

endmodule

/* rtl/core/ppsu_ram.sv */
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module ppsu_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// output holds between reads
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ppsu_ctrl.sv */
// sequencer of the particle pool: clearing pass, request decode, slot walk
// depends on ppsu_pkg; drives ppsu_dpath through cmd_t and reads stat_t

module ppsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ppsu_pkg::action_t in_action,
	output logic              in_ready,
	input  ppsu_pkg::stat_t   stat,
	output ppsu_pkg::cmd_t    cmd
);
	import ppsu_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_SPAWN,
		ST_TICK,
		ST_READ,
		ST_READ_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (in_action)
						ACT_SPAWN: state_d = ST_SEARCH;
						ACT_TICK:  state_d = ST_TICK;
						ACT_READ:  state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				cmd.walk = 1'b1;
				// no free slot found falls back to slot 0, preset at capture
				if (stat.hit || stat.walk_done) begin
					state_d = ST_SPAWN;
				end
			end
			ST_SPAWN: begin
				if (stat.out_free) begin
					cmd.spawn_commit = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_TICK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.walk = 1'b1;
				state_d  = ST_READ_OUT;
			end
			ST_READ_OUT: begin
				if (stat.out_free) begin
					cmd.read_commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/ppsu_dpath.sv */
// datapath of the particle pool: slot ram, walk counters, spawn arithmetic,
// tick update pipeline and result register; depends on ppsu_pkg, ppsu_ram

module ppsu_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppsu_pkg::cmd_t              cmd,
	output ppsu_pkg::stat_t             stat,
	input  ppsu_pkg::item_t             item_data,
	input  logic                        cfg_valid,
	input  logic [ppsu_pkg::CFG_W-1:0]  cfg_data,
	output ppsu_pkg::result_t           res_data,
	output logic                        res_valid,
	input  logic                        res_ready
);
	import ppsu_pkg::*;

	// configuration and walk control
	logic [CFG_W-1:0]  active_q;
	logic [CNT_W-1:0]  count;
	logic [ADDR_W-1:0] start;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] ptr_next;
	logic [CNT_W-1:0]  rem_q;
	logic              issue;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] target_q;
	logic [ADDR_W-1:0] last_q;

	// captured request
	item_t       item_q;
	logic [18:0] five_dt;
	logic [17:0] fade_q;

	// ram
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	slot_rec_t         ram_wdata;
	slot_rec_t         rd_rec;

	// spawn arithmetic
	logic signed [7:0]  off_d;
	logic [6:0]         off_abs;
	logic [13:0]        off_mag14;
	logic [29:0]        off_prod_q;
	logic               off_neg_q;
	logic [11:0]        off_mag;
	logic signed [12:0] off_s;
	logic [23:0]        vx_abs;
	logic [23:0]        vy_abs;
	logic [47:0]        vx_prod_q;
	logic [47:0]        vy_prod_q;
	logic               vx_neg_q;
	logic               vy_neg_q;
	logic [20:0]        vx_q10;
	logic [20:0]        vy_q10;
	slot_rec_t          spawn_rec;

	// tick pipeline
	logic              rd_v_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              live;
	logic [16:0]       life_new;
	logic [16:0]       alpha_new;
	logic [23:0]       mx_abs;
	logic [23:0]       my_abs;
	logic [40:0]       prod_x;
	logic [40:0]       prod_y;

	logic                v_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic                live_s2;
	slot_rec_t           rec_s2;
	logic [16:0]         life_s2;
	logic [16:0]         alpha_s2;
	logic [40:0]         prod_x_s2;
	logic [40:0]         prod_y_s2;
	logic [24:0]         step_x;
	logic [24:0]         step_y;
	logic signed [25:0]  move_x;
	logic signed [25:0]  move_y;
	slot_rec_t           tick_rec;
	logic                tick_we;

	// result register
	logic    res_valid_q;
	result_t res_q;
	logic    read_oob;

	// slot count clamped to 1..POOL_SIZE
	always_comb begin
		if (active_q == '0) begin
			count = CNT_W'(1);
		end else if (int'(active_q) > POOL_SIZE) begin
			count = CNT_W'(POOL_SIZE);
		end else begin
			count = CNT_W'(active_q);
		end
	end

	// a stale last slot restarts the search at slot 0
	assign start    = (CNT_W'(last_q) < count) ? last_q : '0;
	assign ptr_next = ((CNT_W'(ptr_q) + CNT_W'(1)) == count) ? '0 : ptr_q + ADDR_W'(1);
	assign issue    = cmd.walk && (rem_q != '0);
	assign five_dt  = {1'b0, item_data.dt, 2'b00} + 19'(item_data.dt);
	assign read_oob = int'(item_q.read_slot) >= POOL_SIZE;

	assign stat.clear_last = clr_addr_q == ADDR_W'(POOL_SIZE - 1);
	assign stat.hit        = rd_v_s1 && (item_q.action == ACT_SPAWN) && (rd_rec.life == '0);
	assign stat.walk_done  = (rem_q == '0) && !rd_v_s1 && !v_s2;
	assign stat.out_free   = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RESET;
			ptr_q       <= '0;
			rem_q       <= '0;
			clr_addr_q  <= '0;
			target_q    <= '0;
			last_q      <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.capture) begin
				target_q <= '0;
				case (item_data.action)
					ACT_SPAWN: begin
						ptr_q <= start;
						rem_q <= count;
					end
					ACT_TICK: begin
						ptr_q <= '0;
						rem_q <= count;
					end
					ACT_READ: begin
						ptr_q <= ADDR_W'(item_data.read_slot);
						rem_q <= CNT_W'(1);
					end
					default: rem_q <= '0;
				endcase
			end else if (issue) begin
				ptr_q <= ptr_next;
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.walk && stat.hit) begin
				target_q <= addr_s1;
			end
			if (cmd.spawn_commit) begin
				last_q <= target_q;
			end
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1 && (item_q.action == ACT_TICK);
			if (cmd.spawn_commit || cmd.read_commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// spawn arithmetic: offset (pick-50)*128/5 and velocity/10, both
	// rounded half away from zero through reciprocal multiplies
	assign off_d     = $signed({1'b0, item_q.offset_pick}) - OFFSET_CENTRE;
	assign off_abs   = off_d[7] ? 7'(-off_d) : 7'(off_d);
	assign off_mag14 = {off_abs, 7'b0};
	assign vx_abs    = item_q.source_vel_x[23] ? 24'(-item_q.source_vel_x)
		: 24'(item_q.source_vel_x);
	assign vy_abs    = item_q.source_vel_y[23] ? 24'(-item_q.source_vel_y)
		: 24'(item_q.source_vel_y);

	assign off_mag = off_prod_q[29:RECIP_5_SH];
	assign off_s   = off_neg_q ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
	assign vx_q10  = vx_prod_q[47:RECIP_10_SH];
	assign vy_q10  = vy_prod_q[47:RECIP_10_SH];

	always_comb begin
		spawn_rec.life  = LIFE_FULL;
		spawn_rec.pos_x = sat24(26'(item_q.spawn_x) + 26'(off_s));
		spawn_rec.pos_y = sat24(26'(item_q.spawn_y) + 26'(off_s));
		spawn_rec.vel_x = vx_neg_q ? -$signed({3'b0, vx_q10}) : $signed({3'b0, vx_q10});
		spawn_rec.vel_y = vy_neg_q ? -$signed({3'b0, vy_q10}) : $signed({3'b0, vy_q10});
		spawn_rec.alpha = ALPHA_FULL;
		spawn_rec.shade = SHADE_BASE + 8'(item_q.shade_pick);
	end

	// tick stage 1: age, fade and scaled move of the slot just read
	assign live      = rd_rec.life != '0;
	assign life_new  = (rd_rec.life > 17'(item_q.dt)) ? rd_rec.life - 17'(item_q.dt) : '0;
	assign alpha_new = ({1'b0, rd_rec.alpha} > fade_q) ? 17'({1'b0, rd_rec.alpha} - fade_q)
		: '0;
	assign mx_abs    = rd_rec.vel_x[23] ? 24'(-rd_rec.vel_x) : 24'(rd_rec.vel_x);
	assign my_abs    = rd_rec.vel_y[23] ? 24'(-rd_rec.vel_y) : 24'(rd_rec.vel_y);
	assign prod_x    = 41'(mx_abs) * 41'(item_q.dt) + 41'(HALF_Q16);
	assign prod_y    = 41'(my_abs) * 41'(item_q.dt) + 41'(HALF_Q16);

	// tick stage 2: position moves against velocity, saturating
	assign step_x = prod_x_s2[40:16];
	assign step_y = prod_y_s2[40:16];
	assign move_x = rec_s2.vel_x[23] ? 26'(rec_s2.pos_x) + $signed({1'b0, step_x})
		: 26'(rec_s2.pos_x) - $signed({1'b0, step_x});
	assign move_y = rec_s2.vel_y[23] ? 26'(rec_s2.pos_y) + $signed({1'b0, step_y})
		: 26'(rec_s2.pos_y) - $signed({1'b0, step_y});

	always_comb begin
		tick_rec      = rec_s2;
		tick_rec.life = life_s2;
		// a slot that dies on this tick keeps position and alpha
		if (life_s2 != '0) begin
			tick_rec.pos_x = sat24(move_x);
			tick_rec.pos_y = sat24(move_y);
			tick_rec.alpha = alpha_s2;
		end
	end

	assign tick_we = v_s2 && live_s2;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
			fade_q <= 18'((five_dt + 19'd1) >> 1);
		end
		off_prod_q <= 30'(off_mag14 + ROUND_5) * 30'(RECIP_5);
		off_neg_q  <= off_d[7];
		vx_prod_q  <= 48'(vx_abs + ROUND_10) * 48'(RECIP_10);
		vy_prod_q  <= 48'(vy_abs + ROUND_10) * 48'(RECIP_10);
		vx_neg_q   <= item_q.source_vel_x[23];
		vy_neg_q   <= item_q.source_vel_y[23];

		addr_s1   <= ptr_q;
		addr_s2   <= addr_s1;
		live_s2   <= live;
		rec_s2    <= rd_rec;
		life_s2   <= life_new;
		alpha_s2  <= alpha_new;
		prod_x_s2 <= prod_x;
		prod_y_s2 <= prod_y;

		if (cmd.spawn_commit) begin
			res_q.slot  <= SLOT_W'(target_q);
			res_q.pos_x <= spawn_rec.pos_x;
			res_q.pos_y <= spawn_rec.pos_y;
			res_q.alpha <= spawn_rec.alpha;
			res_q.shade <= spawn_rec.shade;
			res_q.alive <= 1'b1;
		end else if (cmd.read_commit) begin
			res_q.slot <= SLOT_W'(item_q.read_slot);
			if (read_oob) begin
				res_q.pos_x <= '0;
				res_q.pos_y <= '0;
				res_q.alpha <= '0;
				res_q.shade <= '0;
				res_q.alive <= 1'b0;
			end else begin
				res_q.pos_x <= rd_rec.pos_x;
				res_q.pos_y <= rd_rec.pos_y;
				res_q.alpha <= rd_rec.alpha;
				res_q.shade <= rd_rec.shade;
				res_q.alive <= rd_rec.life != '0;
			end
		end
	end

	// one write source at a time: clearing pass, spawn load or tick write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s2;
		ram_wdata = tick_rec;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (cmd.spawn_commit) begin
			ram_we    = 1'b1;
			ram_waddr = target_q;
			ram_wdata = spawn_rec;
		end else if (tick_we) begin
			ram_we = 1'b1;
		end
	end

	ppsu_ram #(
		.WIDTH ($bits(slot_rec_t)),
		.DEPTH (POOL_SIZE)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (rd_rec)
	);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
